@@ rtl/core/cc2_pkg.sv @@
// ----------------------------------------------------------------------------
// cc2_pkg
// Shared types and fixed constants of the 2D valid-mode correlation core.
// ----------------------------------------------------------------------------
`default_nettype none

package cc2_pkg;

   // Fixed field widths of the stream and register interface.
   localparam int FIELD_BITS     = 16;
   localparam int SUM_BITS       = 40;
   localparam int ROW_BITS       = 12;
   localparam int IH_BITS        = 13;
   localparam int IW_FIELD_BITS  = 11;
   localparam int KDIM_BITS      = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   // Register limits and reset values.
   localparam int MAX_HEIGHT         = 4096;
   localparam int IMAGE_WIDTH_RESET  = 1024;
   localparam int IMAGE_HEIGHT_RESET = 1024;
   localparam int KERNEL_DIM_RESET   = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_KERNEL_WIDTH  = 2'd2,
      CSR_KERNEL_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACTION_WEIGHT = 1'b0,
      ACTION_PIXEL  = 1'b1
   } action_type;

   typedef struct packed {
      logic [KDIM_BITS-1:0] width;
      logic [KDIM_BITS-1:0] height;
   } kernel_dims_type;

   typedef struct packed {
      logic                 en;
      logic [KDIM_BITS-1:0] row;
      logic [KDIM_BITS-1:0] col;
   } weight_addr_type;

endpackage

`default_nettype wire

@@ rtl/core/valid_cross_correlation_2d_core.sv @@
// ----------------------------------------------------------------------------
// valid_cross_correlation_2d_core
// Streaming valid-mode 2D cross-correlation with a line memory and window.
// ----------------------------------------------------------------------------
// The core takes one beat per clock, either a kernel weight write or the next
// pixel of a raster-order frame, and stalls its input only while a finished
// result sits in the output register with rsp_stall high. A result is ready
// once the pixel completing its window has passed the input register, window
// register, product register and row-sum register into the output register;
// a stall holds the input register and every later register in place.
// Each pixel costs one read and one write of the line memory (MAX_WIDTH words
// of MAX_KERNEL-1 samples, one word per column), which sets the rate of one
// pixel per cycle. Weights take effect for the pixels that follow them, also
// within a frame. Any register write restarts the frame; write registers only
// while the core is idle. The line memory, the window and the kernel are not
// cleared after reset, so load the kernel before the first pixel. When the
// kernel is larger than the image, pixels are taken and no result is given.
// ----------------------------------------------------------------------------
`default_nettype none

module valid_cross_correlation_2d_core #(
   parameter  int MAX_WIDTH  = 1024,
   parameter  int MAX_KERNEL = 5,
   parameter  int DATA_BITS  = 16,
   localparam int COL_BITS   = $clog2(MAX_WIDTH)
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // pixel and weight beats
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_action,
   input  wire logic [cc2_pkg::KDIM_BITS-1:0]           req_weight_row,
   input  wire logic [cc2_pkg::KDIM_BITS-1:0]           req_weight_col,
   input  wire logic signed [cc2_pkg::FIELD_BITS-1:0]   req_weight_value,
   input  wire logic signed [cc2_pkg::FIELD_BITS-1:0]   req_pixel_value,
   // result beats
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic [COL_BITS-1:0]                          rsp_out_col,
   output logic [cc2_pkg::ROW_BITS-1:0]                 rsp_out_row,
   output logic signed [cc2_pkg::SUM_BITS-1:0]          rsp_sum_value,
   output logic                                         rsp_frame_last,
   // register writes
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [cc2_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [cc2_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   localparam int ROW_BITS  = cc2_pkg::ROW_BITS;
   localparam int IH_BITS   = cc2_pkg::IH_BITS;
   localparam int KDIM_BITS = cc2_pkg::KDIM_BITS;
   localparam int IW_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int LINE_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int KIDX_BITS = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int TAG_BITS  = 1 + ROW_BITS + COL_BITS;
   localparam int IW_RESET  = (MAX_WIDTH < cc2_pkg::IMAGE_WIDTH_RESET) ?
                              MAX_WIDTH : cc2_pkg::IMAGE_WIDTH_RESET;
   localparam int KD_RESET  = (MAX_KERNEL < cc2_pkg::KERNEL_DIM_RESET) ?
                              MAX_KERNEL : cc2_pkg::KERNEL_DIM_RESET;

   // ------------------------------------------------------------------------
   // Handshake: the whole pipeline advances together unless the output
   // register holds a result that the receiver stalls.
   // ------------------------------------------------------------------------
   logic advance;
   logic accept;
   logic pixel_accept;

   assign advance      = !(rsp_valid && rsp_stall);
   assign req_stall    = !advance;
   assign accept       = req_valid && advance;
   assign pixel_accept = accept && (req_action == cc2_pkg::ACTION_PIXEL);
   assign csr_ready    = 1'b1;

   // ------------------------------------------------------------------------
   // Configuration registers. Clamp zero to one and large values to the
   // limit; every write restarts the frame.
   // ------------------------------------------------------------------------
   logic [IW_BITS-1:0]                   iw_ff, iw_in;
   logic [IH_BITS-1:0]                   ih_ff, ih_in;
   logic [KDIM_BITS-1:0]                 kw_ff, kw_in;
   logic [KDIM_BITS-1:0]                 kh_ff, kh_in;
   logic                                 cfg_restart;
   logic [cc2_pkg::IW_FIELD_BITS-1:0]    iw_field;
   logic [KDIM_BITS-1:0]                 kd_field;

   assign iw_field = csr_data[cc2_pkg::IW_FIELD_BITS-1:0];
   assign kd_field = csr_data[KDIM_BITS-1:0];

   always_comb begin
      iw_in       = iw_ff;
      ih_in       = ih_ff;
      kw_in       = kw_ff;
      kh_in       = kh_ff;
      cfg_restart = 1'b0;
      if (csr_valid && csr_ready) begin
         cfg_restart = 1'b1;
         unique case (cc2_pkg::csr_index_type'(csr_index))
            cc2_pkg::CSR_IMAGE_WIDTH: begin
               if (iw_field == '0) begin
                  iw_in = IW_BITS'(1);
               end else if (iw_field > MAX_WIDTH) begin
                  iw_in = IW_BITS'(MAX_WIDTH);
               end else begin
                  iw_in = IW_BITS'(iw_field);
               end
            end
            cc2_pkg::CSR_IMAGE_HEIGHT: begin
               if (csr_data == '0) begin
                  ih_in = IH_BITS'(1);
               end else if (csr_data > cc2_pkg::MAX_HEIGHT) begin
                  ih_in = IH_BITS'(cc2_pkg::MAX_HEIGHT);
               end else begin
                  ih_in = csr_data;
               end
            end
            cc2_pkg::CSR_KERNEL_WIDTH: begin
               if (kd_field == '0) begin
                  kw_in = KDIM_BITS'(1);
               end else if (kd_field > MAX_KERNEL) begin
                  kw_in = KDIM_BITS'(MAX_KERNEL);
               end else begin
                  kw_in = kd_field;
               end
            end
            cc2_pkg::CSR_KERNEL_HEIGHT: begin
               if (kd_field == '0) begin
                  kh_in = KDIM_BITS'(1);
               end else if (kd_field > MAX_KERNEL) begin
                  kh_in = KDIM_BITS'(MAX_KERNEL);
               end else begin
                  kh_in = kd_field;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= IW_BITS'(IW_RESET);
         ih_ff <= IH_BITS'(cc2_pkg::IMAGE_HEIGHT_RESET);
         kw_ff <= KDIM_BITS'(KD_RESET);
         kh_ff <= KDIM_BITS'(KD_RESET);
      end else begin
         iw_ff <= iw_in;
         ih_ff <= ih_in;
         kw_ff <= kw_in;
         kh_ff <= kh_in;
      end
   end

   // ------------------------------------------------------------------------
   // Raster position of the next pixel, and what its result will carry.
   // ------------------------------------------------------------------------
   logic [COL_BITS-1:0] col_count_ff, col_count_in;
   logic [ROW_BITS-1:0] row_count_ff, row_count_in;
   logic [COL_BITS:0]   col_next;
   logic [ROW_BITS:0]   row_next;
   logic                emit;
   logic                last;
   logic [COL_BITS-1:0] out_col;
   logic [ROW_BITS-1:0] out_row;

   always_comb begin
      col_next = {1'b0, col_count_ff} + 1'b1;
      row_next = {1'b0, row_count_ff} + 1'b1;
      // a result exists once a full kernel fits above and to the left
      emit = (row_next >= (ROW_BITS+1)'(kh_ff)) && (col_next >= (COL_BITS+1)'(kw_ff));
      last = (row_next == (ROW_BITS+1)'(ih_ff)) && (col_next == (COL_BITS+1)'(iw_ff));
      out_col = COL_BITS'(col_next - (COL_BITS+1)'(kw_ff));
      out_row = ROW_BITS'(row_next - (ROW_BITS+1)'(kh_ff));

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (cfg_restart) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (pixel_accept) begin
         if (col_next >= (COL_BITS+1)'(iw_ff)) begin
            // end of row: wrap the column, and the row at frame end
            col_count_in = '0;
            if (row_next >= (ROW_BITS+1)'(ih_ff)) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_next[ROW_BITS-1:0];
            end
         end else begin
            col_count_in = col_next[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Input register. The line memory read for the pixel is issued at the
   // same edge, so its column word is ready while the pixel sits here.
   // ------------------------------------------------------------------------
   logic                          p0_valid_ff;
   logic                          p0_pixel_ff;
   logic                          p0_emit_ff;
   logic [TAG_BITS-1:0]           p0_tag_ff;
   logic [COL_BITS-1:0]           p0_col_ff;
   logic [KDIM_BITS-1:0]          p0_wrow_ff;
   logic [KDIM_BITS-1:0]          p0_wcol_ff;
   logic signed [DATA_BITS-1:0]   p0_weight_ff;
   logic signed [DATA_BITS-1:0]   p0_sample_ff;
   logic signed [DATA_BITS-1:0]   pixel_sample;
   logic signed [DATA_BITS-1:0]   weight_sample;

   // take the low DATA_BITS of each field as a two's complement value
   assign pixel_sample  = DATA_BITS'($unsigned(req_pixel_value));
   assign weight_sample = DATA_BITS'($unsigned(req_weight_value));

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (advance) begin
         p0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p0_pixel_ff  <= (req_action == cc2_pkg::ACTION_PIXEL);
         p0_emit_ff   <= emit;
         p0_tag_ff    <= {last, out_row, out_col};
         p0_col_ff    <= col_count_ff;
         p0_wrow_ff   <= req_weight_row;
         p0_wcol_ff   <= req_weight_col;
         p0_weight_ff <= weight_sample;
         p0_sample_ff <= pixel_sample;
      end
   end

   // ------------------------------------------------------------------------
   // Line memory and window. Write the updated column word back and shift
   // the window when the pixel leaves the input register.
   // ------------------------------------------------------------------------
   logic                           line_wr_en;
   logic [LINE_ROWS*DATA_BITS-1:0] line_rd_word;
   logic [LINE_ROWS*DATA_BITS-1:0] line_wr_word;
   logic signed [DATA_BITS-1:0]    win [MAX_KERNEL][MAX_KERNEL];

   assign line_wr_en = advance && p0_valid_ff && p0_pixel_ff;

   cc2_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .WIDTH     (LINE_ROWS * DATA_BITS),
      .ADDR_BITS (COL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (pixel_accept),
      .rd_addr (col_count_ff),
      .rd_data (line_rd_word),
      .wr_en   (line_wr_en),
      .wr_addr (p0_col_ff),
      .wr_data (line_wr_word)
   );

   cc2_window #(
      .MAX_KERNEL (MAX_KERNEL),
      .DATA_BITS  (DATA_BITS),
      .LINE_ROWS  (LINE_ROWS)
   ) u_window (
      .clock    (clock),
      .shift_en (line_wr_en),
      .pixel    (p0_sample_ff),
      .line_rd  (line_rd_word),
      .line_wr  (line_wr_word),
      .win      (win)
   );

   // ------------------------------------------------------------------------
   // Kernel, products and adder tree. Only pixels that complete a window
   // travel on; weight beats and other pixels drop out as bubbles.
   // ------------------------------------------------------------------------
   cc2_pkg::weight_addr_type weight_addr;
   cc2_pkg::kernel_dims_type dims;
   logic [TAG_BITS-1:0]      mac_tag;

   assign weight_addr.en  = p0_valid_ff && !p0_pixel_ff;
   assign weight_addr.row = p0_wrow_ff;
   assign weight_addr.col = p0_wcol_ff;
   assign dims.width      = kw_ff;
   assign dims.height     = kh_ff;

   cc2_mac #(
      .MAX_KERNEL (MAX_KERNEL),
      .DATA_BITS  (DATA_BITS),
      .TAG_BITS   (TAG_BITS),
      .KIDX_BITS  (KIDX_BITS)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (p0_valid_ff && p0_pixel_ff && p0_emit_ff),
      .in_tag       (p0_tag_ff),
      .weight_addr  (weight_addr),
      .weight_value (p0_weight_ff),
      .dims         (dims),
      .win          (win),
      .out_valid    (rsp_valid),
      .out_tag      (mac_tag),
      .out_sum      (rsp_sum_value)
   );

   assign rsp_out_col    = mac_tag[COL_BITS-1:0];
   assign rsp_out_row    = mac_tag[COL_BITS +: ROW_BITS];
   assign rsp_frame_last = mac_tag[TAG_BITS-1];

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (col_count_ff == '0 && row_count_ff == '0))
      else $error("register write did not restart the frame");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      (COL_BITS+1)'(col_count_ff) < (COL_BITS+1)'(iw_ff))
      else $error("column counter reached the image width");

   a_line_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !line_wr_en)
      else $error("line memory written while the output is stalled");

endmodule

`default_nettype wire

@@ rtl/core/cc2_line_mem.sv @@
// ----------------------------------------------------------------------------
// cc2_line_mem
// Line memory: one write and one registered read per cycle, write-first.
// ----------------------------------------------------------------------------
`default_nettype none

module cc2_line_mem #(
   parameter int DEPTH     = 1024,
   parameter int WIDTH     = 64,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // forward a same-cycle write to the same word
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/cc2_window.sv @@
// ----------------------------------------------------------------------------
// cc2_window
// Column builder and sliding window of the most recent pixel columns.
// ----------------------------------------------------------------------------
`default_nettype none

module cc2_window #(
   parameter int MAX_KERNEL = 5,
   parameter int DATA_BITS  = 16,
   parameter int LINE_ROWS  = 4
) (
   input  wire logic                           clock,
   input  wire logic                           shift_en,
   input  wire logic signed [DATA_BITS-1:0]    pixel,
   input  wire logic [LINE_ROWS*DATA_BITS-1:0] line_rd,
   output logic      [LINE_ROWS*DATA_BITS-1:0] line_wr,
   output logic signed [DATA_BITS-1:0]         win [MAX_KERNEL][MAX_KERNEL]
);

   logic signed [DATA_BITS-1:0] col_vec [MAX_KERNEL];
   logic signed [DATA_BITS-1:0] win_ff  [MAX_KERNEL][MAX_KERNEL];

   // Entry a of the column is the pixel a rows above the current one.
   always_comb begin
      col_vec[0] = pixel;
      for (int a = 1; a < MAX_KERNEL; a++) begin
         col_vec[a] = line_rd[(a-1)*DATA_BITS +: DATA_BITS];
      end
      // push the new pixel on top of the stored column, drop the oldest row
      line_wr[0 +: DATA_BITS] = pixel;
      for (int j = 1; j < LINE_ROWS; j++) begin
         line_wr[j*DATA_BITS +: DATA_BITS] = line_rd[(j-1)*DATA_BITS +: DATA_BITS];
      end
   end

   // Column 0 holds the newest column; shift older columns right.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int a = 0; a < MAX_KERNEL; a++) begin
            win_ff[a][0] <= col_vec[a];
            for (int b = 1; b < MAX_KERNEL; b++) begin
               win_ff[a][b] <= win_ff[a][b-1];
            end
         end
      end
   end

   assign win = win_ff;

endmodule

`default_nettype wire

@@ rtl/core/cc2_mac.sv @@
// ----------------------------------------------------------------------------
// cc2_mac
// Kernel store, product stage and two-level registered adder tree.
// ----------------------------------------------------------------------------
`default_nettype none

module cc2_mac #(
   parameter int MAX_KERNEL = 5,
   parameter int DATA_BITS  = 16,
   parameter int TAG_BITS   = 23,
   parameter int KIDX_BITS  = 3
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              in_valid,
   input  wire logic [TAG_BITS-1:0]               in_tag,
   input  wire cc2_pkg::weight_addr_type          weight_addr,
   input  wire logic signed [DATA_BITS-1:0]       weight_value,
   input  wire cc2_pkg::kernel_dims_type          dims,
   input  wire logic signed [DATA_BITS-1:0]       win [MAX_KERNEL][MAX_KERNEL],
   output logic                                   out_valid,
   output logic [TAG_BITS-1:0]                    out_tag,
   output logic signed [cc2_pkg::SUM_BITS-1:0]    out_sum
);

   localparam int SUM_W  = cc2_pkg::SUM_BITS;
   localparam int PROD_W = 2 * DATA_BITS;

   logic signed [DATA_BITS-1:0] kernel_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [DATA_BITS-1:0] kern_sel  [MAX_KERNEL][MAX_KERNEL];
   logic signed [DATA_BITS-1:0] win_sel   [MAX_KERNEL][MAX_KERNEL];
   logic [KIDX_BITS-1:0]        kr;
   logic [KIDX_BITS-1:0]        kc;

   logic                        p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic [TAG_BITS-1:0]         p1_tag_ff, p2_tag_ff, p3_tag_ff, p4_tag_ff;
   logic signed [PROD_W-1:0]    prod_ff   [MAX_KERNEL][MAX_KERNEL];
   logic signed [SUM_W-1:0]     rowsum_in [MAX_KERNEL];
   logic signed [SUM_W-1:0]     rowsum_ff [MAX_KERNEL];
   logic signed [SUM_W-1:0]     sum_in;
   logic signed [SUM_W-1:0]     sum_ff;

   // Hold weights; write when the weight beat leaves the input stage.
   always_ff @(posedge clock) begin
      if (advance && weight_addr.en && (weight_addr.row < MAX_KERNEL) &&
          (weight_addr.col < MAX_KERNEL)) begin
         kernel_ff[KIDX_BITS'(weight_addr.row)][KIDX_BITS'(weight_addr.col)] <= weight_value;
      end
   end

   // Window entry (a,b) is a rows and b columns back from the newest pixel,
   // so it meets kernel entry (height-1-a, width-1-b). Zero inactive taps.
   always_comb begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
         for (int b = 0; b < MAX_KERNEL; b++) begin
            kr = '0;
            kc = '0;
            kern_sel[a][b] = '0;
            win_sel[a][b]  = '0;
            if ((a < int'(dims.height)) && (b < int'(dims.width))) begin
               kr = KIDX_BITS'(int'(dims.height) - 1 - a);
               kc = KIDX_BITS'(int'(dims.width) - 1 - b);
               kern_sel[a][b] = kernel_ff[kr][kc];
               win_sel[a][b]  = win[a][b];
            end
         end
      end
   end

   always_comb begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
         rowsum_in[a] = '0;
         for (int b = 0; b < MAX_KERNEL; b++) begin
            rowsum_in[a] = rowsum_in[a] + SUM_W'(prod_ff[a][b]);
         end
      end
      sum_in = '0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
         sum_in = sum_in + rowsum_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_tag_ff <= in_tag;
         p2_tag_ff <= p1_tag_ff;
         p3_tag_ff <= p2_tag_ff;
         p4_tag_ff <= p3_tag_ff;
         for (int a = 0; a < MAX_KERNEL; a++) begin
            for (int b = 0; b < MAX_KERNEL; b++) begin
               prod_ff[a][b] <= PROD_W'(win_sel[a][b]) * PROD_W'(kern_sel[a][b]);
            end
            rowsum_ff[a] <= rowsum_in[a];
         end
         sum_ff <= sum_in;
      end
   end

   assign out_valid = p4_valid_ff;
   assign out_tag   = p4_tag_ff;
   assign out_sum   = sum_ff;

endmodule

`default_nettype wire
